@@ hw/rtl/akl_pkg.sv @@
// Shared types, codes and helpers of the analogue ladder keypad event unit.
package akl_pkg;

    localparam int unsigned SAMPLE_BITS = 10;
    localparam int unsigned LEVEL_BITS  = 10;
    localparam int unsigned MAX_BUTTONS = 6;
    localparam int unsigned BTN_W       = 3;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned IVAL_W      = 16;
    localparam int unsigned LEVELS_W    = MAX_BUTTONS * LEVEL_BITS;
    localparam int unsigned APB_DATA_W  = 64;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned REG_IDX_W   = 2;

    localparam logic [BTN_W-1:0] NONE_CODE = 3'd7;
    localparam logic [BTN_W-1:0] BTN_MAX   = BTN_W'(MAX_BUTTONS);

    // Reset values of the configuration registers.
    localparam logic [IVAL_W-1:0] IVAL_RESET = 16'd1000;

    // Long-press modes. Code 3 starts the timer but never reports a long-press.
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_HOLD    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE     = 2'd0,
        REG_INTERVAL = 2'd1,
        REG_COUNT    = 2'd2,
        REG_LEVELS   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_POLL       = 1'b0,
        CMD_SET_REPEAT = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic [1:0]          mode;
        logic [IVAL_W-1:0]   interval;
        logic [BTN_W-1:0]    count;
        logic [LEVELS_W-1:0] levels;
    } t_cfg;

    typedef struct packed {
        logic                   command;
        logic [SAMPLE_BITS-1:0] adc_level;
        logic [TIME_W-1:0]      now_ms;
        logic                   repeat_value;
    } t_in_item;

    // Classified item as it travels from the front part to the back part.
    typedef struct packed {
        logic              command;
        logic [BTN_W-1:0]  reading;
        logic [TIME_W-1:0] now_ms;
        logic              repeat_value;
    } t_cls_item;

    // Number of buttons in use, clamped to the ladder size.
    function automatic logic [BTN_W-1:0] active_count(input logic [BTN_W-1:0] count);
        return (count > BTN_MAX) ? BTN_MAX : count;
    endfunction

endpackage

@@ hw/rtl/akl_in_if.sv @@
// Input channel of the keypad unit: poll and set-repeat items.
interface akl_in_if import akl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [SAMPLE_BITS-1:0] adc_level;
    logic [TIME_W-1:0]      now_ms;
    logic                   repeat_value;

    modport source (output valid, output command, output adc_level, output now_ms,
                    output repeat_value, input ready);
    modport sink (input valid, input command, input adc_level, input now_ms,
                  input repeat_value, output ready);
endinterface

@@ hw/rtl/akl_out_if.sv @@
// Output channel of the keypad unit: key events.
interface akl_out_if import akl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] button_index;
    logic [1:0]       event_kind;

    modport source (output valid, output button_index, output event_kind, input ready);
    modport sink (input valid, input button_index, input event_kind, output ready);
endinterface

@@ hw/rtl/akl_cfg_regs.sv @@
// APB register file holding the keypad configuration.
module akl_cfg_regs import akl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_idx)
                REG_MODE:     n_cfg.mode     = pwdata[1:0];
                REG_INTERVAL: n_cfg.interval = pwdata[IVAL_W-1:0];
                REG_COUNT:    n_cfg.count    = pwdata[BTN_W-1:0];
                REG_LEVELS:   n_cfg.levels   = pwdata[LEVELS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:     prdata = APB_DATA_W'(r_cfg.mode);
            REG_INTERVAL: prdata = APB_DATA_W'(r_cfg.interval);
            REG_COUNT:    prdata = APB_DATA_W'(r_cfg.count);
            REG_LEVELS:   prdata = APB_DATA_W'(r_cfg.levels);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= MODE_NONE;
            r_cfg.interval <= IVAL_RESET;
            r_cfg.count    <= '0;
            r_cfg.levels   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ hw/rtl/akl_front.sv @@
// Front part: accepts input items and classifies the sample against the trigger levels.
module akl_front import akl_pkg::*; (
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  logic      i_q_full,
    output logic      o_push,
    output t_cls_item o_push_item
);

    logic [BTN_W-1:0]      w_active;
    logic [BTN_W-1:0]      w_reading;
    logic [LEVEL_BITS-1:0] w_level;

    assign w_active = active_count(i_cfg.count);
    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && !i_q_full;

    // Walk from the top so that the lowest matching button index wins.
    always_comb begin
        w_reading = NONE_CODE;
        w_level   = '0;
        for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
            w_level = i_cfg.levels[i*LEVEL_BITS +: LEVEL_BITS];
            if ((BTN_W'(i) < w_active) && (i_item.adc_level < w_level)) begin
                w_reading = BTN_W'(i);
            end
        end
    end

    always_comb begin
        o_push_item.command      = i_item.command;
        o_push_item.reading      = w_reading;
        o_push_item.now_ms       = i_item.now_ms;
        o_push_item.repeat_value = i_item.repeat_value;
    end

endmodule

@@ hw/rtl/akl_queue.sv @@
// Two-entry queue between the front and back parts.
module akl_queue import akl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_push_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cls_item o_head
);

    t_cls_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

@@ hw/rtl/akl_back.sv @@
// Back part: key state, long-press timer and the registered event output.
module akl_back import akl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_cls_item        i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [BTN_W-1:0] o_button_index,
    output logic [1:0]       o_event_kind
);

    logic [BTN_W-1:0]  r_held;
    logic [BTN_W-1:0]  n_held;
    logic              r_timer_run;
    logic              n_timer_run;
    logic [TIME_W-1:0] r_timer_start;
    logic [TIME_W-1:0] n_timer_start;
    logic              r_repeat;
    logic              n_repeat;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [BTN_W-1:0]  r_out_btn;
    logic [BTN_W-1:0]  n_out_btn;
    t_event_kind       r_out_kind;
    t_event_kind       n_out_kind;

    logic [BTN_W-1:0]  w_held;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_expired;
    logic              w_emit;

    assign o_pop          = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid        = r_out_valid;
    assign o_button_index = r_out_btn;
    assign o_event_kind   = r_out_kind;

    // A stored code at or beyond the buttons in use means nothing is held.
    assign w_held    = (r_held < active_count(i_cfg.count)) ? r_held : NONE_CODE;
    assign w_elapsed = i_head.now_ms - r_timer_start;
    assign w_expired = r_timer_run && (w_elapsed >= TIME_W'(i_cfg.interval));

    always_comb begin
        n_held        = r_held;
        n_timer_run   = r_timer_run;
        n_timer_start = r_timer_start;
        n_repeat      = r_repeat;
        n_out_btn     = r_out_btn;
        n_out_kind    = r_out_kind;
        w_emit        = 1'b0;

        if (o_pop) begin
            if (i_head.command == CMD_SET_REPEAT) begin
                n_repeat = i_head.repeat_value;
            end else begin
                priority if (i_head.reading == NONE_CODE) begin
                    if (w_held != NONE_CODE) begin
                        w_emit      = 1'b1;
                        n_out_btn   = w_held;
                        n_out_kind  = (i_cfg.mode == MODE_RELEASE && w_expired) ?
                                      EV_LONG : EV_RELEASE;
                        n_timer_run = 1'b0;
                        n_repeat    = 1'b0;
                    end
                end else if (w_held == NONE_CODE) begin
                    w_emit     = 1'b1;
                    n_out_btn  = i_head.reading;
                    n_out_kind = EV_PRESS;
                    if (i_cfg.mode != MODE_NONE) begin
                        n_timer_run   = 1'b1;
                        n_timer_start = i_head.now_ms;
                    end
                end else if (i_cfg.mode == MODE_HOLD && w_expired) begin
                    w_emit      = 1'b1;
                    n_out_btn   = i_head.reading;
                    n_out_kind  = EV_LONG;
                    n_timer_run = 1'b0;
                end else if (r_repeat) begin
                    w_emit     = 1'b1;
                    n_out_btn  = w_held;
                    n_out_kind = EV_PRESS;
                end else begin
                    w_emit = 1'b0;
                end
                // Moving straight from one button to another gives no release event and no press of the new button.
                n_held = i_head.reading;
            end
        end

        n_out_valid = o_pop ? w_emit : (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        r_out_btn  <= n_out_btn;
        r_out_kind <= n_out_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= NONE_CODE;
            r_timer_run   <= 1'b0;
            r_timer_start <= '0;
            r_repeat      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_held        <= n_held;
            r_timer_run   <= n_timer_run;
            r_timer_start <= n_timer_start;
            r_repeat      <= n_repeat;
            r_out_valid   <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/analog_ladder_keypad_events_unit.sv @@
// Keypad event unit for a resistor-ladder keypad. It takes one item per clock unless the queue is
// full: a poll carrying an ADC sample and a millisecond timestamp, or a set-repeat command. A poll
// is classified against the trigger levels as it is accepted, waits in a two-entry queue, and is
// turned into at most one press, release or long-press event by the key state logic. Each event
// is registered in the output register, so it passes through the queue and then that register.
// The output register and the queue let input transfers continue while an event waits to be taken.
// Configuration is written over APB at byte addresses 0, 8, 16 and 24 (mode, long-press interval,
// button count, packed trigger levels) and should only be changed while the unit is idle.
module analog_ladder_keypad_events_unit import akl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    akl_in_if.sink                i_in_item,
    akl_out_if.source             o_event,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      w_cfg;
    t_in_item  w_in_item;
    t_cls_item w_push_item;
    t_cls_item w_head;
    logic      w_push;
    logic      w_pop;
    logic      w_q_full;
    logic      w_q_valid;
    logic      w_front_ready;

    always_comb begin
        w_in_item.command      = i_in_item.command;
        w_in_item.adc_level    = i_in_item.adc_level;
        w_in_item.now_ms       = i_in_item.now_ms;
        w_in_item.repeat_value = i_in_item.repeat_value;
    end

    assign i_in_item.ready = w_front_ready;

    akl_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    akl_front u_front (
        .i_valid     (i_in_item.valid),
        .o_ready     (w_front_ready),
        .i_item      (w_in_item),
        .i_cfg       (w_cfg),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    akl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_head      (w_head)
    );

    akl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_valid      (w_q_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_event.valid),
        .i_ready        (o_event.ready),
        .o_button_index (o_event.button_index),
        .o_event_kind   (o_event.event_kind)
    );

endmodule
